// File: design/rftc_pkg.sv
// Shared types and constants of the radio frame type classifier.
package rftc_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 9;
  localparam int unsigned ClassW = 2;

  localparam logic [CountW-1:0] CountSat     = 9'd256;
  localparam logic [CountW-1:0] BcastMinLen  = 9'd16;
  localparam logic [CountW-1:0] MaxFrameLen  = 9'd255;
  localparam logic [CountW-1:0] JoinReqLen   = 9'd23;
  localparam logic [CountW-1:0] JoinAccLen   = 9'd17;
  localparam logic [CountW-1:0] JoinAccLenCf = 9'd33;
  localparam logic [CountW-1:0] DataMinLen   = 9'd8;
  localparam logic [CountW-1:0] DataHdrLen   = 9'd12;
  localparam logic [CountW-1:0] MeshMaxPath  = 9'd64;
  localparam logic [CountW-1:0] MeshMaxPay   = 9'd184;
  localparam logic [ByteW-1:0]  BcastByte    = 8'hFF;

  localparam logic [3:0] PtypeRsvLo = 4'hC;
  localparam logic [3:0] PtypeRsvHi = 4'hE;

  typedef enum logic [ClassW-1:0] {
    CLS_UNKNOWN = 2'd0,
    CLS_BCAST   = 2'd1,
    CLS_LORAWAN = 2'd2,
    CLS_MESH    = 2'd3
  } class_e;

  typedef enum logic [2:0] {
    MT_JOIN_REQ   = 3'd0,
    MT_JOIN_ACC   = 3'd1,
    MT_UNCONF_UP  = 3'd2,
    MT_UNCONF_DN  = 3'd3,
    MT_CONF_UP    = 3'd4,
    MT_CONF_DN    = 3'd5,
    MT_REJOIN     = 3'd6,
    MT_PROPRIET   = 3'd7
  } mtype_e;

  typedef enum logic [1:0] {
    RT_TRANSPORT_FLOOD  = 2'd0,
    RT_FLOOD            = 2'd1,
    RT_DIRECT           = 2'd2,
    RT_TRANSPORT_DIRECT = 2'd3
  } route_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last;
  } item_t;

  typedef struct packed {
    logic   push;
    class_e frame_class;
  } result_t;

endpackage

// File: design/rftc_if.sv
// Byte and class stream interfaces of the radio frame type classifier.
interface rftc_byte_if;
  logic                        valid;
  logic                        ready;
  logic [rftc_pkg::ByteW-1:0]  data_byte;
  logic                        last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface rftc_class_if;
  logic                        valid;
  logic                        ready;
  logic [rftc_pkg::ClassW-1:0] frame_class;

  modport source (output valid, output frame_class, input ready);
  modport sink   (input valid, input frame_class, output ready);
endinterface

// File: design/radio_frame_type_classifier.sv
// Top level of the radio frame type classifier.
// Takes one payload byte per cycle on byte_in_i and gives one class per frame on
// class_out_o after the byte marked last: 0 unknown, 1 broadcast mesh, 2 LoRaWAN,
// 3 routed mesh. Each byte passes an input register, then an update of the frame
// counters and captured header bytes; on the last byte the class is decided in
// that same cycle and loaded into the result register, which drives class_out_o.
// Sustained rate is one byte per cycle; a held result only stalls input when
// another last byte needs the result register.
module radio_frame_type_classifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  rftc_byte_if.sink   byte_in_i,
  rftc_class_if.source class_out_o
);

  rftc_pkg::item_t   in_item;
  rftc_pkg::item_t   item;
  rftc_pkg::result_t result;
  rftc_pkg::class_e  out_class;
  logic              item_valid;
  logic              item_take;
  logic              res_free;

  assign in_item.data_byte = byte_in_i.data_byte;
  assign in_item.last      = byte_in_i.last;

  rftc_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (byte_in_i.valid),
    .in_ready_o   (byte_in_i.ready),
    .in_item_i    (in_item),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  rftc_frame_tracker u_frame_tracker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .res_free_i   (res_free),
    .result_o     (result)
  );

  rftc_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .result_i     (result),
    .res_free_o   (res_free),
    .out_valid_o  (class_out_o.valid),
    .out_ready_i  (class_out_o.ready),
    .out_class_o  (out_class)
  );

  assign class_out_o.frame_class = out_class;

endmodule

// File: design/rftc_in_stage.sv
// Input register stage of the radio frame type classifier.
module rftc_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rftc_pkg::item_t     in_item_i,
  output logic                item_valid_o,
  output rftc_pkg::item_t     item_o,
  input  logic                item_take_i
);

  logic            valid_q, valid_d;
  rftc_pkg::item_t item_q;
  logic            load;

  assign in_ready_o = !valid_q || item_take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (item_take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// File: design/rftc_frame_tracker.sv
// Per-frame state and end-of-frame classification of the radio frame type classifier.
module rftc_frame_tracker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  rftc_pkg::item_t   item_i,
  output logic              item_take_o,
  input  logic              res_free_i,
  output rftc_pkg::result_t result_o
);

  localparam int unsigned CW = rftc_pkg::CountW;
  localparam int unsigned BW = rftc_pkg::ByteW;

  logic [CW-1:0] count_q, count_d, len;
  logic [BW-1:0] header_q, header_d, header_n;
  logic [BW-1:0] second_q, second_d, second_n;
  logic [BW-1:0] sixth_q, sixth_d, sixth_n;
  logic          bseen_q, bseen_d, bseen_n;

  logic          is_bcast, is_lora, is_mesh;
  logic [2:0]    mtype;
  logic [3:0]    ptype;
  logic [1:0]    route;
  logic          long_hdr;
  logic [BW-1:0] plb;
  logic [CW-1:0] pos;
  logic [BW-1:0] hsize;
  logic [BW-1:0] path;
  logic [CW-1:0] need_len;
  rftc_pkg::class_e cls;

  assign item_take_o = item_valid_i && (!item_i.last || res_free_i);

  always_comb begin
    header_n = header_q;
    second_n = second_q;
    sixth_n  = sixth_q;
    bseen_n  = bseen_q;
    if (count_q == 9'd0) begin
      header_n = item_i.data_byte;
    end else if (count_q == 9'd1) begin
      second_n = item_i.data_byte;
    end else if (count_q == 9'd5) begin
      sixth_n = item_i.data_byte;
    end
    if (count_q < 9'd4 && item_i.data_byte != rftc_pkg::BcastByte) begin
      bseen_n = 1'b0;
    end
    len = (count_q < rftc_pkg::CountSat) ? count_q + 9'd1 : count_q;
  end

  assign is_bcast = len >= rftc_pkg::BcastMinLen && len <= rftc_pkg::MaxFrameLen && bseen_n;

  assign mtype = header_n[7:5];

  always_comb begin
    is_lora = 1'b0;
    if (header_n[4:0] == 5'd0) begin
      case (rftc_pkg::mtype_e'(mtype))
        rftc_pkg::MT_JOIN_REQ: is_lora = (len == rftc_pkg::JoinReqLen);
        rftc_pkg::MT_JOIN_ACC: is_lora = (len == rftc_pkg::JoinAccLen) ||
                                         (len == rftc_pkg::JoinAccLenCf);
        rftc_pkg::MT_UNCONF_UP, rftc_pkg::MT_UNCONF_DN,
        rftc_pkg::MT_CONF_UP, rftc_pkg::MT_CONF_DN: begin
          is_lora = (len >= rftc_pkg::DataMinLen) &&
                    (len >= rftc_pkg::DataHdrLen + {5'd0, sixth_n[3:0]});
        end
        default: is_lora = 1'b0;
      endcase
    end
  end

  assign route    = header_n[1:0];
  assign ptype    = header_n[5:2];
  assign long_hdr = (route == rftc_pkg::RT_TRANSPORT_FLOOD) ||
                    (route == rftc_pkg::RT_TRANSPORT_DIRECT);
  assign plb      = long_hdr ? sixth_n : second_n;
  assign pos      = long_hdr ? 9'd6 : 9'd2;
  assign hsize    = {6'd0, plb[7:6]} + 8'd1;
  assign path     = 8'({2'd0, plb[5:0]} * hsize);
  assign need_len = pos + {1'b0, path};

  always_comb begin
    is_mesh = 1'b1;
    if (len < 9'd2 || len > rftc_pkg::MaxFrameLen) begin
      is_mesh = 1'b0;
    end
    if (header_n[7:6] != 2'd0) begin
      is_mesh = 1'b0;
    end
    if (ptype >= rftc_pkg::PtypeRsvLo && ptype <= rftc_pkg::PtypeRsvHi) begin
      is_mesh = 1'b0;
    end
    if (len < pos) begin
      is_mesh = 1'b0;
    end
    if (plb[7:6] == 2'b11) begin
      is_mesh = 1'b0;
    end
    if ({1'b0, path} > rftc_pkg::MeshMaxPath) begin
      is_mesh = 1'b0;
    end
    if (len < need_len) begin
      is_mesh = 1'b0;
    end else if (len - need_len > rftc_pkg::MeshMaxPay) begin
      is_mesh = 1'b0;
    end
  end

  always_comb begin
    if (is_bcast) begin
      cls = rftc_pkg::CLS_BCAST;
    end else if (is_lora) begin
      cls = rftc_pkg::CLS_LORAWAN;
    end else if (is_mesh) begin
      cls = rftc_pkg::CLS_MESH;
    end else begin
      cls = rftc_pkg::CLS_UNKNOWN;
    end
  end

  assign result_o.push        = item_take_o && item_i.last;
  assign result_o.frame_class = cls;

  always_comb begin
    count_d  = count_q;
    header_d = header_q;
    second_d = second_q;
    sixth_d  = sixth_q;
    bseen_d  = bseen_q;
    if (item_take_o) begin
      if (item_i.last) begin
        count_d  = '0;
        header_d = '0;
        second_d = '0;
        sixth_d  = '0;
        bseen_d  = 1'b1;
      end else begin
        count_d  = len;
        header_d = header_n;
        second_d = second_n;
        sixth_d  = sixth_n;
        bseen_d  = bseen_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      header_q <= '0;
      second_q <= '0;
      sixth_q  <= '0;
      bseen_q  <= 1'b1;
    end else begin
      count_q  <= count_d;
      header_q <= header_d;
      second_q <= second_d;
      sixth_q  <= sixth_d;
      bseen_q  <= bseen_d;
    end
  end

`ifndef ASSERT_OFF
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.push |=> count_q == '0 && bseen_q)
    else $error("frame state not cleared after last byte");

  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= rftc_pkg::CountSat)
    else $error("byte count beyond saturation");

  a_bcast_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.push && result_o.frame_class == rftc_pkg::CLS_BCAST |->
      header_n == rftc_pkg::BcastByte && len >= rftc_pkg::BcastMinLen)
    else $error("broadcast class without broadcast header");
`endif

endmodule

// File: design/rftc_out_stage.sv
// Result register of the radio frame type classifier.
module rftc_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rftc_pkg::result_t result_i,
  output logic              res_free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rftc_pkg::class_e  out_class_o
);

  logic             valid_q, valid_d;
  rftc_pkg::class_e class_q;

  assign res_free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (result_i.push) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result_i.push) begin
      class_q <= result_i.frame_class;
    end
  end

  assign out_valid_o = valid_q;
  assign out_class_o = class_q;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_i.push |-> res_free_o)
    else $error("result pushed into an occupied register");
`endif

endmodule

// File: verif/radio_frame_type_classifier_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the radio frame type classifier, checked against a frame predictor.
module radio_frame_type_classifier_tb;
  import rftc_pkg::*;

  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned RandomBytes = 1600;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned NumSteps    = 25;

  typedef enum logic [1:0] {
    FK_NOISE,
    FK_BCAST,
    FK_LORAWAN,
    FK_MESH
  } frame_kind_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last;
    logic             typed;
    class_e           frame_class;
  } step_row_t;

  localparam step_row_t DirectedSteps [NumSteps] = '{
    '{8'h00, 1'b1, 1'b1, CLS_UNKNOWN},
    '{8'hFF, 1'b1, 1'b1, CLS_UNKNOWN},
    '{8'h05, 1'b0, 1'b0, CLS_UNKNOWN},
    '{8'h00, 1'b1, 1'b1, CLS_MESH},
    '{8'h00, 1'b0, 1'b0, CLS_UNKNOWN},
    '{8'h3F, 1'b1, 1'b1, CLS_UNKNOWN},
    '{8'hFF, 1'b0, 1'b0, CLS_UNKNOWN},
    '{8'hFF, 1'b0, 1'b0, CLS_UNKNOWN},
    '{8'hFF, 1'b0, 1'b0, CLS_UNKNOWN},
    '{8'hFF, 1'b0, 1'b0, CLS_UNKNOWN},
    '{8'h00, 1'b0, 1'b0, CLS_UNKNOWN},
    '{8'h80, 1'b0, 1'b0, CLS_UNKNOWN},
    '{8'h7F, 1'b0, 1'b0, CLS_UNKNOWN},
    '{8'h01, 1'b0, 1'b0, CLS_UNKNOWN},
    '{8'hAA, 1'b0, 1'b0, CLS_UNKNOWN},
    '{8'h55, 1'b0, 1'b0, CLS_UNKNOWN},
    '{8'hF0, 1'b0, 1'b0, CLS_UNKNOWN},
    '{8'h0F, 1'b0, 1'b0, CLS_UNKNOWN},
    '{8'hC3, 1'b0, 1'b0, CLS_UNKNOWN},
    '{8'h3C, 1'b0, 1'b0, CLS_UNKNOWN},
    '{8'hFE, 1'b0, 1'b0, CLS_UNKNOWN},
    '{8'h5A, 1'b1, 1'b1, CLS_BCAST},
    '{8'h40, 1'b1, 1'b1, CLS_UNKNOWN},
    '{8'h80, 1'b1, 1'b0, CLS_UNKNOWN},
    '{8'hE0, 1'b1, 1'b0, CLS_UNKNOWN}
  };

  logic clk_i;
  logic rst_ni;

  rftc_byte_if  byte_if ();
  rftc_class_if class_if ();

  radio_frame_type_classifier dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_in_i   (byte_if),
    .class_out_o (class_if)
  );

  logic [CountW-1:0] frame_len = '0;
  logic [ByteW-1:0]  hdr_q     = '0;
  logic [ByteW-1:0]  byte1_q   = '0;
  logic [ByteW-1:0]  byte5_q   = '0;
  logic              ff_prefix = 1'b1;

  class_e           expected_classes [$];
  class_e           oldest_class;
  logic [ByteW-1:0] frame_q [$];
  int unsigned      mismatches  = 0;
  int unsigned      idle_cycles = 0;
  int unsigned      burst_left  = 0;
  logic             no_gaps     = 1'b0;
  int unsigned      stall_left  = 0;
  logic [15:0]      rx_cycle    = '0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic class_e classify_frame();
    int unsigned      n;
    int unsigned      pos;
    int unsigned      hsize;
    int unsigned      path;
    logic [ByteW-1:0] plb;
    n = frame_len;
    if (n >= BcastMinLen && n <= MaxFrameLen && ff_prefix) return CLS_BCAST;
    if (hdr_q[4:0] == 5'd0) begin
      case (mtype_e'(hdr_q[7:5]))
        MT_JOIN_REQ: if (n == JoinReqLen) return CLS_LORAWAN;
        MT_JOIN_ACC: if (n == JoinAccLen || n == JoinAccLenCf) return CLS_LORAWAN;
        MT_UNCONF_UP, MT_UNCONF_DN, MT_CONF_UP, MT_CONF_DN: begin
          if (n >= DataMinLen && n >= DataHdrLen + byte5_q[3:0]) return CLS_LORAWAN;
        end
        default: ;
      endcase
    end
    if (n < 2 || n > MaxFrameLen || hdr_q[7:6] != 2'b00) return CLS_UNKNOWN;
    if (hdr_q[5:2] >= PtypeRsvLo && hdr_q[5:2] <= PtypeRsvHi) return CLS_UNKNOWN;
    pos = 1;
    if (route_e'(hdr_q[1:0]) == RT_TRANSPORT_FLOOD ||
        route_e'(hdr_q[1:0]) == RT_TRANSPORT_DIRECT) begin
      pos = 5;
    end
    if (n < pos + 1) return CLS_UNKNOWN;
    plb = (pos == 1) ? byte1_q : byte5_q;
    pos = pos + 1;
    hsize = plb[7:6] + 1;
    if (hsize == 4) return CLS_UNKNOWN;
    path = plb[5:0] * hsize;
    if (path > MeshMaxPath || n < pos + path) return CLS_UNKNOWN;
    return (n - pos - path <= MeshMaxPay) ? CLS_MESH : CLS_UNKNOWN;
  endfunction

  task automatic take_byte(input logic [ByteW-1:0] b, input logic lst, output class_e cls);
    case (frame_len)
      9'd0: hdr_q = b;
      9'd1: byte1_q = b;
      9'd5: byte5_q = b;
      default: ;
    endcase
    if (frame_len < 4 && b != BcastByte) ff_prefix = 1'b0;
    if (frame_len < CountSat) frame_len = frame_len + 1'b1;
    cls = CLS_UNKNOWN;
    if (lst) begin
      cls       = classify_frame();
      frame_len = '0;
      hdr_q     = '0;
      byte1_q   = '0;
      byte5_q   = '0;
      ff_prefix = 1'b1;
    end
  endtask

  task automatic send_byte(input logic [ByteW-1:0] b, input logic lst, input logic typed,
                           input class_e typed_cls);
    int unsigned gap;
    class_e      cls;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0 || no_gaps) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        byte_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    byte_if.valid     <= 1'b1;
    byte_if.data_byte <= b;
    byte_if.last      <= lst;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
    take_byte(b, lst, cls);
    if (lst) expected_classes = {expected_classes, (typed ? typed_cls : cls)};
    @(negedge clk_i);
  endtask

  task automatic build_frame(input int unsigned frame_no);
    frame_kind_e      kind;
    mtype_e           mt;
    int               len;
    int unsigned      pos;
    int unsigned      hcode;
    int unsigned      hops;
    int unsigned      pay;
    logic [3:0]       nib;
    logic [ByteW-1:0] hdr;
    kind = (frame_no < 3) ? ((frame_no == 1) ? FK_LORAWAN : FK_BCAST)
                          : frame_kind_e'($urandom_range(0, 3));
    nib  = 4'($urandom_range(0, 15));
    pos  = 1;
    hdr  = '0;
    case (kind)
      FK_BCAST: len = $urandom_range(14, 40);
      FK_LORAWAN: begin
        mt  = (frame_no == 1) ? MT_UNCONF_UP : mtype_e'($urandom_range(0, 7));
        hdr = {mt, 5'b00000};
        if (frame_no >= 3 && $urandom_range(0, 7) == 0) hdr[4:0] = 5'($urandom_range(1, 31));
        case (mt)
          MT_JOIN_REQ: len = ($urandom_range(0, 1) == 0) ? JoinReqLen : $urandom_range(20, 26);
          MT_JOIN_ACC: begin
            case ($urandom_range(0, 2))
              0: len = JoinAccLen;
              1: len = JoinAccLenCf;
              default: len = $urandom_range(15, 35);
            endcase
          end
          default: len = DataHdrLen + nib + $urandom_range(0, 6) - 3;
        endcase
      end
      FK_MESH: begin
        hdr = {2'b00, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3))};
        if ($urandom_range(0, 9) == 0) hdr[7:6] = 2'($urandom_range(1, 3));
        if (route_e'(hdr[1:0]) == RT_TRANSPORT_FLOOD ||
            route_e'(hdr[1:0]) == RT_TRANSPORT_DIRECT) begin
          pos = 5;
        end
        hcode = ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2);
        hops  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                            : $urandom_range(0, 64 / (hcode + 1));
        pay   = ($urandom_range(0, 19) == 0) ? $urandom_range(178, 190) : $urandom_range(0, 12);
        len   = pos + 1 + hops * (hcode + 1) + pay;
        if ($urandom_range(0, 7) == 0) len = len + $urandom_range(0, 6) - 3;
      end
      default: len = $urandom_range(1, 12);
    endcase
    if (frame_no < 3) len = MaxFrameLen + frame_no;
    else if ($urandom_range(0, 199) == 0) len = $urandom_range(250, 270);
    if (len < 1) len = 1;

    frame_q.delete();
    repeat (len) frame_q = {frame_q, ByteW'($urandom_range(0, 255))};
    case (kind)
      FK_BCAST: begin
        for (int i = 0; i < 4 && i < len; i++) frame_q[i] = BcastByte;
        if (frame_no >= 3 && $urandom_range(0, 5) == 0) begin
          frame_q[$urandom_range(0, (len < 4) ? len - 1 : 3)] = ByteW'($urandom_range(0, 255));
        end
      end
      FK_LORAWAN: begin
        frame_q[0] = hdr;
        if (len > 5) frame_q[5] = {frame_q[5][7:4], nib};
      end
      FK_MESH: begin
        frame_q[0] = hdr;
        if (len > pos) frame_q[pos] = {2'(hcode), 6'(hops)};
      end
      default: ;
    endcase
  endtask

  initial begin
    class_if.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      rx_cycle++;
      if (stall_left == 0 && !rx_cycle[8] && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 12);
      end
      class_if.ready <= (stall_left == 0);
      if (stall_left != 0) stall_left--;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && class_if.valid && class_if.ready) begin
      if (expected_classes.size() == 0) begin
        $error("frame_class: expected none, actual %0d", class_if.frame_class);
        mismatches++;
      end else begin
        oldest_class = expected_classes.pop_front();
        if (class_if.frame_class !== oldest_class) begin
          $error("frame_class: expected %0d, actual %0d", oldest_class, class_if.frame_class);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (byte_if.valid && byte_if.ready) || (class_if.valid && class_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("radio_frame_type_classifier_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned sent;
    int unsigned frame_no;
    byte_if.valid     <= 1'b0;
    byte_if.data_byte <= '0;
    byte_if.last      <= 1'b0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (DirectedSteps[i]) begin
      send_byte(DirectedSteps[i].data_byte, DirectedSteps[i].last, DirectedSteps[i].typed,
                DirectedSteps[i].frame_class);
    end

    sent     = 0;
    frame_no = 0;
    while (sent < RandomBytes) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      build_frame(frame_no);
      foreach (frame_q[j]) send_byte(frame_q[j], j == frame_q.size() - 1, 1'b0, CLS_UNKNOWN);
      sent += frame_q.size();
      frame_no++;
    end
    byte_if.valid <= 1'b0;

    while (expected_classes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("radio_frame_type_classifier_tb OK");
    end else begin
      $display("radio_frame_type_classifier_tb NOT OK");
    end
    $finish;
  end

endmodule
